/* rtl/core/b2da_pkg.sv */
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int NumDigits  = 10;
    localparam int ValueWidth = 32;
    localparam int CharWidth  = 6;
    localparam int StepWidth  = $clog2(ValueWidth);
    localparam int IndexWidth = $clog2(NumDigits);

    localparam logic [ValueWidth-1:0] LimitValue = 32'd1000000000;
    localparam logic [CharWidth-1:0]  AsciiZero  = 6'd48;
    localparam logic [CharWidth-1:0]  AsciiNine  = 6'd57;
    localparam logic [CharWidth-1:0]  NullChar   = 6'd0;
    localparam logic [StepWidth-1:0]  LastStep   = StepWidth'(ValueWidth - 1);

    typedef logic [3:0] digit_t;

    // Control shared by every digit cell in the chain.
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CONV   = 5'b00010,
        ST_FIND   = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_REJECT = 5'b10000
    } state_t;

endpackage

/* rtl/core/b2da_digit_cell.sv */
`timescale 1ns / 1ps

// One BCD digit: add 3 when the digit is five or more, then shift left
// taking the neighbor's carry into bit 0 and passing bit 3 upward.
module b2da_digit_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  b2da_pkg::cell_ctrl_t ctrl,
    input  logic                carry_in,
    output logic                carry_out,
    output b2da_pkg::digit_t    digit
);

    b2da_pkg::digit_t digit_reg;
    b2da_pkg::digit_t digit_next;
    b2da_pkg::digit_t adjusted;

    always_comb begin
        adjusted = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.shift) begin
            digit_next = {adjusted[2:0], carry_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= '0;
        end else begin
            digit_reg <= digit_next;
        end
    end

    assign carry_out = adjusted[3];
    assign digit     = digit_reg;

endmodule

/* rtl/core/binary_to_decimal_ascii.sv */
`timescale 1ns / 1ps

// Channel  Dir  Beat contents (lowest bit first)
// s_       in   tdata[31:0] = value
// m_       out  tdata[5:0] = digit_char, tdata[7:6] = 0; tlast = last; tuser = too_large
//
// A value is accepted, its 32 bits are shifted through the digit chain, the
// leading digit is located, then one character goes out per cycle while
// m_tready stays high. A rejected value (above 1000000000) gives its single beat.
// Reset (aresetn low, synchronous) clears the sequencer, the digit cells and
// the output valid flag. m_tready low holds the output beat and stalls emission;
// the last beat may still wait while the next value is accepted.
module binary_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic        m_tlast,
    output logic        m_tuser    // [0] too_large
);

    localparam int N = b2da_pkg::NumDigits;

    b2da_pkg::state_t                             state_reg, state_next;
    logic [b2da_pkg::ValueWidth-1:0]              shift_reg, shift_next;
    logic [b2da_pkg::StepWidth-1:0]               step_reg, step_next;
    logic [b2da_pkg::IndexWidth-1:0]              idx_reg, idx_next;
    logic                                         m_valid_reg, m_valid_next;
    logic [b2da_pkg::CharWidth-1:0]               m_char_reg, m_char_next;
    logic                                         m_last_reg, m_last_next;
    logic                                         m_big_reg, m_big_next;

    b2da_pkg::cell_ctrl_t                         ctrl;
    b2da_pkg::digit_t                             digits [N];
    logic [N:0]                                   carry;
    logic [b2da_pkg::IndexWidth-1:0]              top;
    logic                                         s_accept;
    logic                                         slot_free;

    // Digit chain: cell 0 is the least significant digit and takes the
    // top bit of the binary shift register.
    assign carry[0] = shift_reg[b2da_pkg::ValueWidth-1];

    for (genvar g = 0; g < N; g++) begin : g_cell
        b2da_digit_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .carry_in  (carry[g]),
            .carry_out (carry[g+1]),
            .digit     (digits[g])
        );
    end

    // Locate the most significant nonzero digit; all zero points at digit 0.
    always_comb begin
        top = '0;
        for (int d = 0; d < N; d++) begin
            if (digits[d] != 4'd0) begin
                top = b2da_pkg::IndexWidth'(d);
            end
        end
    end

    assign s_tready  = (state_reg == b2da_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        shift_next   = shift_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_big_next   = m_big_reg;
        ctrl.clear   = 1'b0;
        ctrl.shift   = 1'b0;

        case (state_reg)
            b2da_pkg::ST_IDLE: begin
                if (s_accept) begin
                    // Load the value and clear the chain for a fresh conversion.
                    shift_next = s_tdata;
                    step_next  = '0;
                    ctrl.clear = 1'b1;
                    if (s_tdata > b2da_pkg::LimitValue) begin
                        state_next = b2da_pkg::ST_REJECT;
                    end else begin
                        state_next = b2da_pkg::ST_CONV;
                    end
                end
            end
            b2da_pkg::ST_CONV: begin
                // Advance the chain one bit per cycle.
                ctrl.shift = 1'b1;
                shift_next = {shift_reg[b2da_pkg::ValueWidth-2:0], 1'b0};
                step_next  = step_reg + 1'b1;
                if (step_reg == b2da_pkg::LastStep) begin
                    state_next = b2da_pkg::ST_FIND;
                end
            end
            b2da_pkg::ST_FIND: begin
                idx_next   = top;
                state_next = b2da_pkg::ST_EMIT;
            end
            b2da_pkg::ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = b2da_pkg::AsciiZero + {2'b00, digits[idx_reg]};
                    m_last_next  = (idx_reg == '0);
                    m_big_next   = 1'b0;
                    if (idx_reg == '0) begin
                        state_next = b2da_pkg::ST_IDLE;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            b2da_pkg::ST_REJECT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = b2da_pkg::NullChar;
                    m_last_next  = 1'b1;
                    m_big_next   = 1'b1;
                    state_next   = b2da_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = b2da_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= b2da_pkg::ST_IDLE;
            step_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            shift_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            shift_reg   <= shift_next;
        end
    end

    // Output payload holds while the beat waits; no reset needed.
    always_ff @(posedge aclk) begin
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_big_reg  <= m_big_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_char_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_big_reg;

    // A rejected value must go straight to its single null beat.
    a_reject_path: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tdata > b2da_pkg::LimitValue) |=> state_reg == b2da_pkg::ST_REJECT)
        else $error("oversize value did not take the reject path");

    // A rejected beat is always a lone null character.
    a_reject_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("reject beat is not a final null character");

    // Every beat of a converted (not rejected) value carries an ASCII digit.
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            (m_tdata[5:0] >= b2da_pkg::AsciiZero) && (m_tdata[5:0] <= b2da_pkg::AsciiNine))
        else $error("emitted character is not a decimal digit");

    // The conversion ends on the last shift step.
    a_conv_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == b2da_pkg::ST_CONV) && (step_reg == b2da_pkg::LastStep)
            |=> state_reg == b2da_pkg::ST_FIND)
        else $error("conversion did not end on the last shift step");

endmodule

/* dv/digit_stream_checker.sv */
`timescale 1ns / 1ps

module digit_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [5:0] digit_char, [7:6] zero
    input  logic        m_tlast,
    input  logic        m_tuser,   // [0] too_large
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [b2da_pkg::CharWidth-1:0] digit_char;
        logic                           last;
        logic                           too_large;
    } char_beat_t;

    char_beat_t expected_chars[$];
    int         error_count = 0;

    // Double dabble over ten BCD digits, then queue the characters from the
    // leading nonzero digit down; an oversized value queues a single null beat.
    function automatic void queue_decimal_chars(
            input logic [b2da_pkg::ValueWidth-1:0] value);
        b2da_pkg::digit_t                bcd [b2da_pkg::NumDigits];
        logic [b2da_pkg::ValueWidth-1:0] shreg;
        logic                            carry;
        logic                            spill;
        int                              lead;
        char_beat_t                      beat;
        if (value > b2da_pkg::LimitValue) begin
            beat.digit_char = b2da_pkg::NullChar;
            beat.last       = 1'b1;
            beat.too_large  = 1'b1;
            expected_chars.push_back(beat);
            return;
        end
        for (int d = 0; d < b2da_pkg::NumDigits; d++) bcd[d] = '0;
        shreg = value;
        for (int step = 0; step < b2da_pkg::ValueWidth; step++) begin
            for (int d = 0; d < b2da_pkg::NumDigits; d++) begin
                if (bcd[d] >= 4'd5) bcd[d] = bcd[d] + 4'd3;
            end
            carry = shreg[b2da_pkg::ValueWidth-1];
            for (int d = 0; d < b2da_pkg::NumDigits; d++) begin
                spill  = bcd[d][3];
                bcd[d] = {bcd[d][2:0], carry};
                carry  = spill;
            end
            shreg = shreg << 1;
        end
        lead = 0;
        for (int d = b2da_pkg::NumDigits - 1; d >= 0; d--) begin
            if (bcd[d] != 4'd0 && lead == 0) lead = d;
        end
        for (int d = lead; d >= 0; d--) begin
            beat.digit_char = b2da_pkg::AsciiZero + b2da_pkg::CharWidth'(bcd[d]);
            beat.last       = (d == 0);
            beat.too_large  = 1'b0;
            expected_chars.push_back(beat);
        end
    endfunction

    always @(posedge aclk) begin
        char_beat_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    if (error_count < 10)
                        $display("%0t: unexpected beat tdata=%h tlast=%b tuser=%b",
                                 $realtime, m_tdata, m_tlast, m_tuser);
                    error_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== {2'b00, want.digit_char} || m_tlast !== want.last
                            || m_tuser !== want.too_large) begin
                        if (error_count < 10)
                            $display("%0t: beat mismatch exp tdata=%h tlast=%b tuser=%b, %s",
                                     $realtime, {2'b00, want.digit_char}, want.last,
                                     want.too_large,
                                     $sformatf("got tdata=%h tlast=%b tuser=%b",
                                               m_tdata, m_tlast, m_tuser));
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) queue_decimal_chars(s_tdata);
        end
        mismatches  <= error_count;
        outstanding <= expected_chars.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int CycleLimit = 1000000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // [31:0] value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [5:0] digit_char, [7:6] zero
    logic        m_tlast;
    logic        m_tuser;           // [0] too_large

    int mismatches;
    int outstanding;
    int cycle_count = 0;

    // Sink pacing state: current segment length left.
    int ready_hold = 0;
    // Source pacing: items left in a stretch with no gaps.
    int burst_left = 0;

    binary_to_decimal_ascii dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    digit_stream_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Drive m_tready in segments: long ready stretches, short toggles, and
    // now and then a long stall. One assignment per edge.
    always @(posedge aclk) begin
        int roll;
        if (ready_hold == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(30, 80);
            end else if (roll < 60) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 3);
            end else if (roll < 92) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    // Gap before the next input beat: mostly none or short, a few long,
    // with occasional stretches of back-to-back beats.
    function automatic int pick_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            burst_left = $urandom_range(10, 20);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random value: mostly convertible numbers, some digit-count edges,
    // some around the limit, and a share of full-range (mostly rejected) words.
    function automatic logic [31:0] pick_value();
        int          roll;
        logic [31:0] pow;
        roll = $urandom_range(0, 99);
        if (roll < 45) return $urandom_range(0, 1000000000);
        if (roll < 60) return $urandom_range(0, 999);
        if (roll < 70) begin
            pow = 32'd1;
            repeat ($urandom_range(0, 9)) pow = pow * 10;
            return pow + $urandom_range(0, 2) - 1;
        end
        if (roll < 80) return b2da_pkg::LimitValue + $urandom_range(0, 10) - 5;
        return $urandom();
    endfunction

    // Present one value, idling first if asked; hold tvalid across
    // back-to-back beats so it never drops and rises in one step.
    task automatic send_value(input logic [31:0] value, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) begin
                s_tdata <= $urandom();
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Block until every expected beat has been seen.
    task automatic drain_results();
        do @(posedge aclk); while (outstanding != 0);
    endtask

    logic [31:0] directed_values [] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd7, 32'd999,
        32'd12345, 32'd123456789, 32'd9999999, 32'd10000000, 32'd500000000,
        32'd536870911, 32'd999999999, 32'd1000000000, 32'd1000000001,
        32'd1073741824, 32'd2147483647, 32'h80000000, 32'hFFFFFFFE,
        32'hFFFFFFFF, 32'd1000000000, 32'd0
    };

    initial begin
        // Hold reset low from time zero, then release it.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: digit-count extremes, zero, the limit and just past it,
        // full-scale words; half of them back to back.
        foreach (directed_values[i])
            send_value(directed_values[i], (i % 2) ? 0 : $urandom_range(0, 4));
        s_tvalid <= 1'b0;

        // Pause the source until the sink has drained everything.
        drain_results();

        for (int n = 0; n < 210; n++) begin
            send_value(pick_value(), pick_gap());
            if (n == 105) begin
                s_tvalid <= 1'b0;
                drain_results();
            end
        end
        s_tvalid <= 1'b0;

        // Let the last beats out, then settle.
        drain_results();
        repeat (60) @(posedge aclk);

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
